/* src/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the greedy box suppression block
// Widths, word layouts, register indexes and the comparison unit status.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int KEEP_DEPTH = 64;
    localparam int COORD_BITS = 16;

    localparam int ADDR_W  = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
    localparam int CNT_W   = $clog2(KEEP_DEPTH + 1);
    localparam int AREA_W  = 2 * COORD_BITS;
    localparam int UNION_W = AREA_W + 1;
    localparam int THR_W   = 17;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = THR_W + UNION_W;
    localparam int CMP_W   = (PROD_W > AREA_W + FRAC_W) ? PROD_W : AREA_W + FRAC_W;
    localparam int MAXK_W  = 7;
    localparam int LIM_W   = (CNT_W > MAXK_W) ? CNT_W : MAXK_W;
    localparam int ORD_W   = 16;
    localparam int KCNT_W  = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (THR_W > MAXK_W) ? THR_W : MAXK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEEP = 1'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 17'd45875;
    localparam logic [MAXK_W-1:0] MAXK_RESET = 7'd64;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_box;

    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_keep_entry;

    typedef struct packed {
        logic   new_set;
        t_coord box_xmin;
        t_coord box_ymin;
        t_coord box_xmax;
        t_coord box_ymax;
    } t_box_in;

    typedef struct packed {
        logic              kept;
        logic              list_full;
        logic [ORD_W-1:0]  box_ordinal;
        logic [KCNT_W-1:0] kept_count;
    } t_box_out;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_iou_stat;

endpackage

/* src/gbn_keep_ram.sv */
// ----------------------------------------------------------------------------
// gbn_keep_ram: simple dual-port RAM for the kept list
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gbn_keep_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gbn_iou.sv */
// ----------------------------------------------------------------------------
// gbn_iou: pipelined overlap test against one kept box per cycle
// Six stages: RAM alignment, overlap, intersection, union, product, compare.
// ----------------------------------------------------------------------------
module gbn_iou (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_issue,
    input  gbn_pkg::t_box                   i_cand,
    input  logic [gbn_pkg::AREA_W-1:0]      i_cand_area,
    input  logic [gbn_pkg::THR_W-1:0]       i_thr,
    input  gbn_pkg::t_keep_entry            i_entry,
    output gbn_pkg::t_iou_stat              o_stat
);

    localparam int C = gbn_pkg::COORD_BITS;

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_dis1, r_dis2, r_dis3, r_dis4;
    logic r_hit5;

    logic [C-1:0]                 r_iw, r_ih;
    logic [gbn_pkg::AREA_W-1:0]   r_areab1, r_areab2;
    logic [gbn_pkg::AREA_W-1:0]   r_inter2, r_inter3, r_inter4;
    logic [gbn_pkg::UNION_W-1:0]  r_uni3;
    logic [gbn_pkg::PROD_W-1:0]   r_prod4;

    logic         w_dis;
    logic [C-1:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic [gbn_pkg::CMP_W-1:0] w_lhs, w_rhs;

    // overlap window of candidate and stored box
    always_comb begin
        w_dis  = (i_cand.x0 > i_entry.box.x1) || (i_cand.x1 < i_entry.box.x0) ||
                 (i_cand.y0 > i_entry.box.y1) || (i_cand.y1 < i_entry.box.y0);
        w_lo_x = (i_cand.x0 > i_entry.box.x0) ? i_cand.x0 : i_entry.box.x0;
        w_hi_x = (i_cand.x1 < i_entry.box.x1) ? i_cand.x1 : i_entry.box.x1;
        w_lo_y = (i_cand.y0 > i_entry.box.y0) ? i_cand.y0 : i_entry.box.y0;
        w_hi_y = (i_cand.y1 < i_entry.box.y1) ? i_cand.y1 : i_entry.box.y1;
    end

    assign w_lhs = gbn_pkg::CMP_W'({r_inter4, {gbn_pkg::FRAC_W{1'b0}}});
    assign w_rhs = gbn_pkg::CMP_W'(r_prod4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v0 <= i_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        // overlap
        r_dis1   <= w_dis;
        r_iw     <= w_hi_x - w_lo_x;
        r_ih     <= w_hi_y - w_lo_y;
        r_areab1 <= i_entry.area;
        // intersection area
        r_dis2   <= r_dis1;
        r_areab2 <= r_areab1;
        r_inter2 <= gbn_pkg::AREA_W'(r_iw) * gbn_pkg::AREA_W'(r_ih);
        // union area
        r_dis3   <= r_dis2;
        r_inter3 <= r_inter2;
        r_uni3   <= gbn_pkg::UNION_W'(i_cand_area) + gbn_pkg::UNION_W'(r_areab2)
                    - gbn_pkg::UNION_W'(r_inter2);
        // threshold times union
        r_dis4   <= r_dis3;
        r_inter4 <= r_inter3;
        r_prod4  <= gbn_pkg::PROD_W'(i_thr) * gbn_pkg::PROD_W'(r_uni3);
        // drop test
        r_hit5   <= !r_dis4 && (w_lhs > w_rhs);
    end

    assign o_stat.busy      = r_v0 | r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_stat.hit_valid = r_v5;
    assign o_stat.hit       = r_hit5;

endmodule

/* src/greedy_box_nms.sv */
// ----------------------------------------------------------------------------
// greedy_box_nms: greedy non-maximum suppression on intersection over union
// One box at a time: a box is taken only while idle, and its result word is
//   registered when its scan ends, or after the area step when the list is full.
//   The single RAM read port feeds the pipeline one kept box per cycle; the
//   receiver cannot stall. Reset (synchronous, active low) empties the list,
//   zeroes the ordinal and loads the register defaults; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module greedy_box_nms (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // box word in
    input  logic                               i_start,
    input  gbn_pkg::t_box_in                   i_box,
    output logic                               o_busy,
    // result word out
    output logic                               o_valid,
    output gbn_pkg::t_box_out                  o_result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_AREA  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;

    logic [2:0] r_state, n_state;

    // configuration registers
    logic [gbn_pkg::THR_W-1:0]  r_thr;
    logic [gbn_pkg::MAXK_W-1:0] r_maxk;

    // list and set state
    logic [gbn_pkg::CNT_W-1:0]  r_total;
    logic [gbn_pkg::ORD_W-1:0]  r_ord;
    logic [gbn_pkg::ORD_W-1:0]  r_ord_cur;

    // current box
    gbn_pkg::t_box              r_cand;
    logic [gbn_pkg::AREA_W-1:0] r_area;
    logic [gbn_pkg::CNT_W-1:0]  r_idx;
    logic                       r_supp;

    // result register
    logic                       r_valid;
    gbn_pkg::t_box_out          r_result;

    logic                       w_accept;
    logic                       w_issue;
    logic                       w_finish;
    logic                       w_full;
    logic                       w_we;
    logic [gbn_pkg::LIM_W-1:0]  w_limit;
    logic [gbn_pkg::ORD_W-1:0]  w_ord_start;
    gbn_pkg::t_box              w_clamped;
    gbn_pkg::t_keep_entry       w_wentry;
    gbn_pkg::t_keep_entry       w_rentry;
    logic [$bits(gbn_pkg::t_keep_entry)-1:0] w_rdata;
    gbn_pkg::t_iou_stat         w_stat;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // limit: zero acts as one, saturate at the list depth
    always_comb begin
        w_limit = gbn_pkg::LIM_W'(r_maxk);
        if (r_maxk == '0) begin
            w_limit = gbn_pkg::LIM_W'(1);
        end
        if (w_limit > gbn_pkg::LIM_W'(gbn_pkg::KEEP_DEPTH)) begin
            w_limit = gbn_pkg::LIM_W'(gbn_pkg::KEEP_DEPTH);
        end
    end

    assign w_full = gbn_pkg::LIM_W'(r_total) >= w_limit;

    // inverted edges collapse onto the low edge
    always_comb begin
        w_clamped.x0 = i_box.box_xmin;
        w_clamped.y0 = i_box.box_ymin;
        w_clamped.x1 = (i_box.box_xmax < i_box.box_xmin) ? i_box.box_xmin : i_box.box_xmax;
        w_clamped.y1 = (i_box.box_ymax < i_box.box_ymin) ? i_box.box_ymin : i_box.box_ymax;
    end

    assign w_ord_start = i_box.new_set ? '0 : r_ord;

    // one read per kept entry, then wait for the pipeline to empty
    assign w_issue  = (r_state == S_SCAN) && (r_idx != r_total);
    assign w_finish = (r_state == S_DRAIN) && !w_stat.busy;
    assign w_we     = w_finish && !r_supp;

    assign w_wentry.box  = r_cand;
    assign w_wentry.area = r_area;
    assign w_rentry      = gbn_pkg::t_keep_entry'(w_rdata);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_AREA;
                end
            end
            S_AREA: begin
                n_state = w_full ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == r_total) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_stat.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= gbn_pkg::THR_RESET;
            r_maxk  <= gbn_pkg::MAXK_RESET;
            r_total <= '0;
            r_ord   <= '0;
            r_valid <= 1'b0;
            r_supp  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gbn_pkg::CFG_IOU_THR:  r_thr  <= i_cfg_data[gbn_pkg::THR_W-1:0];
                    gbn_pkg::CFG_MAX_KEEP: r_maxk <= i_cfg_data[gbn_pkg::MAXK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                // new set: empty the list before this box
                if (i_box.new_set) begin
                    r_total <= '0;
                end
                r_ord <= w_ord_start + gbn_pkg::ORD_W'(1);
            end
            if (r_state == S_AREA) begin
                r_idx  <= '0;
                r_supp <= 1'b0;
                if (w_full) begin
                    r_valid <= 1'b1;
                end
            end
            if (w_issue) begin
                r_idx <= r_idx + gbn_pkg::CNT_W'(1);
            end
            if (w_stat.hit_valid && w_stat.hit) begin
                r_supp <= 1'b1;
            end
            if (w_finish) begin
                r_valid <= 1'b1;
                if (!r_supp) begin
                    r_total <= r_total + gbn_pkg::CNT_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cand    <= w_clamped;
            r_ord_cur <= w_ord_start;
        end
        if (r_state == S_AREA) begin
            r_area <= gbn_pkg::AREA_W'(r_cand.x1 - r_cand.x0)
                      * gbn_pkg::AREA_W'(r_cand.y1 - r_cand.y0);
            // full list: report and drop
            r_result.kept        <= 1'b0;
            r_result.list_full   <= 1'b1;
            r_result.box_ordinal <= r_ord_cur;
            r_result.kept_count  <= gbn_pkg::KCNT_W'(r_total);
        end
        if (w_finish) begin
            r_result.kept        <= !r_supp;
            r_result.list_full   <= 1'b0;
            r_result.box_ordinal <= r_ord_cur;
            r_result.kept_count  <= gbn_pkg::KCNT_W'(r_total + gbn_pkg::CNT_W'(!r_supp));
        end
    end

    gbn_keep_ram #(
        .DEPTH (gbn_pkg::KEEP_DEPTH),
        .WIDTH ($bits(gbn_pkg::t_keep_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_total[gbn_pkg::ADDR_W-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_idx[gbn_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    gbn_iou u_iou (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_cand      (r_cand),
        .i_cand_area (r_area),
        .i_thr       (r_thr),
        .i_entry     (w_rentry),
        .o_stat      (w_stat)
    );

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // the list never grows past its depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= gbn_pkg::CNT_W'(gbn_pkg::KEEP_DEPTH))
        else $error("kept list count beyond depth");

    // a result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // kept and full are exclusive, and a kept box leaves a non-empty list
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.kept && o_result.list_full) &&
                    (!o_result.kept || (o_result.kept_count != '0)))
        else $error("inconsistent result flags");

    // comparison results only arrive while a box is being scanned or drained
    a_hit_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.hit_valid |-> (r_state == S_SCAN) || (r_state == S_DRAIN))
        else $error("comparison result outside scan");

    // no RAM write while reads are still in flight
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_issue && !w_stat.busy)
        else $error("list write overlaps a scan");

endmodule
